[rtl/rqps_pkg.sv]
// ============================================================================
// rqps_pkg: shared types and constants for the ready queue scheduler
// Holds entry layout, policy and request codes, sequencer states and the policy comparison.
// ============================================================================
package rqps_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 54;
    localparam int OUT_CNT_W   = 7;

    localparam logic [2:0] POL_RR   = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_SRTN = 3'd2;
    localparam logic [2:0] POL_GUAR = 3'd3;
    localparam logic [2:0] POL_PRIO = 3'd4;
    // unassigned codes, handled as round robin
    localparam logic [2:0] POL_RSV5 = 3'd5;
    localparam logic [2:0] POL_RSV6 = 3'd6;
    localparam logic [2:0] POL_RSV7 = 3'd7;

    localparam logic REQ_ADD      = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    typedef struct packed {
        logic [5:0]         id;
        logic [15:0]        target;
        logic [15:0]        served;
        logic signed [15:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    // candidate c strictly beats best b under policy pol
    function automatic logic beats(input logic [2:0] pol, input t_entry c,
                                   input t_entry b);
        logic signed [16:0] rc;
        logic signed [16:0] rb;
        logic [31:0]        pc;
        logic [31:0]        pb;
        rc = $signed({1'b0, c.target}) - $signed({1'b0, c.served});
        rb = $signed({1'b0, b.target}) - $signed({1'b0, b.served});
        pc = c.served * b.target;
        pb = b.served * c.target;
        case (pol)
            POL_SJF:  beats = c.target < b.target;
            POL_SRTN: beats = rc < rb;
            POL_GUAR: beats = pc < pb;
            POL_PRIO: beats = c.prio > b.prio;
            default:  beats = 1'b0;
        endcase
    endfunction

endpackage

[rtl/ready_queue_policy_scheduler_unit.sv]
// ============================================================================
// ready_queue_policy_scheduler_unit: policy-driven ready queue
// Ordered queue in a RAM; dispatch scans for the winner and compacts.
// ============================================================================
//  channel | dir | contents, lowest bits first
//  s_axis  | in  | request: tdata {id, target, served, prio}; tuser {req_type, requeue}
//  m_axis  | out | result: tdata {chosen_id, count}; tuser {picked, idle, dropped}
//  apb     | in  | policy register at byte address 0
//
// An add (or an idle dispatch) goes through ST_DONE, which loads the result; the next request
// is accepted only back in ST_IDLE, once the output register is empty.
// A dispatch (after any requeue) scans every entry in ST_SCAN, one RAM read per cycle
// through the registered read port, then compacts in ST_SHIFT, one move per cycle, the
// entries past the winner when it is not the last entry, and loads the result in ST_DONE.
// The single read port forces this serial scan and compaction.
// Reset clears state, policy, count and output valid; RAM contents are never read unset.
// A waiting result blocks the input until the output register empties.
module ready_queue_policy_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] proc_id, [21:6] target_time, [37:22] served_time,
    // [53:38] priority_req, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [0] req_type, [1] requeue_running
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] chosen_id, [12:6] queue_count, [15:13] zero
    output logic [15:0] m_axis_tdata,
    // [0] picked, [1] idle, [2] dropped
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = rqps_pkg::IDX_W;
    localparam int CW = rqps_pkg::CNT_W;
    localparam int OW = rqps_pkg::OUT_CNT_W;

    rqps_pkg::t_state r_state, n_state;
    logic [2:0]        r_policy;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_i;       // scan / shift read index
    logic              r_ph;      // shift: rdata holds entry r_i-1
    logic [IW-1:0]     r_best;
    rqps_pkg::t_entry  r_best_e;
    logic [5:0]        r_chosen;
    logic              r_dropped;
    logic              r_picked;
    logic              r_idle;
    logic              r_ovalid;
    logic [15:0]       r_odata;
    logic [2:0]        r_ouser;

    logic              we;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    rqps_pkg::t_entry  wdata;
    rqps_pkg::t_entry  rdata;
    logic [rqps_pkg::ENTRY_W-1:0] rraw;

    logic              acc;
    logic              is_dispatch;
    logic              in_append;
    logic              full;
    logic              app_ok;
    logic [CW-1:0]     cnt_add;
    logic [CW-1:0]     cnt_out;
    rqps_pkg::t_entry  in_entry;
    logic              scan_take;
    logic [IW-1:0]     scan_best;
    logic              scan_last;
    logic              shift_more;

    rqps_ram #(.WIDTH(rqps_pkg::ENTRY_W), .DEPTH(rqps_pkg::QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rraw)
    );
    assign rdata = rraw;

    // APB: single policy register, always ready
    assign pready = 1'b1;
    assign prdata = {29'd0, r_policy};

    assign s_axis_tready = (r_state == rqps_pkg::ST_IDLE) && !r_ovalid;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign is_dispatch   = s_axis_tuser[0] == rqps_pkg::REQ_DISPATCH;
    assign in_append     = !is_dispatch || s_axis_tuser[1];
    assign full          = r_count == CW'(rqps_pkg::QUEUE_DEPTH);
    assign app_ok        = in_append && !full;
    assign cnt_add       = r_count + CW'(app_ok);
    assign in_entry      = {s_axis_tdata[5:0], s_axis_tdata[21:6],
                            s_axis_tdata[37:22], s_axis_tdata[53:38]};

    // scan: rdata holds entry r_i-1; the first entry always becomes the best
    assign scan_take  = (r_i == CW'(1)) || rqps_pkg::beats(r_policy, rdata, r_best_e);
    assign scan_best  = scan_take ? IW'(r_i - CW'(1)) : r_best;
    assign scan_last  = r_i == r_count;
    assign shift_more = r_i < r_count;
    assign cnt_out    = r_picked ? r_count - CW'(1) : r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rqps_pkg::ST_IDLE: begin
                if (acc) begin
                    if (is_dispatch && cnt_add != '0) n_state = rqps_pkg::ST_SCAN;
                    else n_state = rqps_pkg::ST_DONE;
                end
            end
            rqps_pkg::ST_SCAN: begin
                // skip compaction when the winner is the last entry
                if (scan_last) begin
                    if (CW'(scan_best) + CW'(1) < r_count) n_state = rqps_pkg::ST_SHIFT;
                    else n_state = rqps_pkg::ST_DONE;
                end
            end
            rqps_pkg::ST_SHIFT: begin
                if (!shift_more) n_state = rqps_pkg::ST_DONE;
            end
            rqps_pkg::ST_DONE: n_state = rqps_pkg::ST_IDLE;
            default: n_state = rqps_pkg::ST_IDLE;
        endcase
    end

    // memory control: append at tail; shift reads r_i and writes the previous read one place
    // down, at r_i-2, so read and write never hit the same entry
    always_comb begin
        we    = 1'b0;
        waddr = r_count[IW-1:0];
        wdata = in_entry;
        raddr = r_i[IW-1:0];
        case (r_state)
            rqps_pkg::ST_IDLE: we = acc && app_ok;
            rqps_pkg::ST_SHIFT: begin
                we    = r_ph;
                waddr = IW'(r_i - CW'(2));
                wdata = rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rqps_pkg::ST_IDLE;
            r_policy <= rqps_pkg::POL_RR;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_ph     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == 1'b0)
                r_policy <= pwdata[2:0];
            if (r_state == rqps_pkg::ST_DONE) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                rqps_pkg::ST_IDLE: begin
                    if (acc) begin
                        r_count   <= cnt_add;
                        r_dropped <= in_append && full;
                        r_picked  <= 1'b0;
                        r_idle    <= is_dispatch && cnt_add == '0;
                        r_chosen  <= '0;
                        r_i       <= '0;
                    end
                end
                rqps_pkg::ST_SCAN: begin
                    if (r_i != '0 && scan_take) begin
                        r_best   <= scan_best;
                        r_best_e <= rdata;
                    end
                    if (scan_last) begin
                        // hand over to compaction starting just past the winner
                        r_picked <= 1'b1;
                        r_chosen <= scan_take ? rdata.id : r_best_e.id;
                        r_i      <= CW'(scan_best) + CW'(1);
                        r_ph     <= 1'b0;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                rqps_pkg::ST_SHIFT: begin
                    if (shift_more) begin
                        r_i  <= r_i + CW'(1);
                        r_ph <= 1'b1;
                    end
                end
                rqps_pkg::ST_DONE: begin
                    r_count <= cnt_out;
                    r_odata <= {3'b000, OW'(cnt_out), r_chosen};
                    r_ouser <= {r_dropped, r_idle, r_picked};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(rqps_pkg::QUEUE_DEPTH)) else $error("count overflow");
    no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != rqps_pkg::ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
    out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser)) else $error("result changed while waiting");
    shift_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rqps_pkg::ST_SHIFT && we |-> CW'(waddr) + CW'(1) < r_count)
        else $error("shift write past queue end");
endmodule

[rtl/rqps_ram.sv]
// ============================================================================
// rqps_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered.
// ============================================================================
module rqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
